// File: hdl/bpa_pkg.sv
package bpa_pkg;

   // Managed region geometry
   localparam int PAGE_COUNT = 1024;
   localparam int PAGE_SHIFT = 12;

   // Bitmap layout: 32 pages per RAM word
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int PIDX_W     = WIDX_W + BIT_W;

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);

   // Bits of the last word past the end of the region always read as used
   localparam logic [WORD_BITS-1:0] LAST_PAD =
      (PAGE_COUNT % WORD_BITS == 0) ? '0 :
      ~((WORD_BITS'(1) << (PAGE_COUNT % WORD_BITS)) - WORD_BITS'(1));

   localparam logic [31:0] BASE_RESET = 32'd4000;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_ALLOCATED   = 2'd0;
   localparam logic [1:0] ST_NO_MEMORY   = 2'd1;
   localparam logic [1:0] ST_FREED       = 2'd2;
   localparam logic [1:0] ST_BAD_ADDRESS = 2'd3;

   typedef struct packed {
      logic [31:0] page_address;
      logic [1:0]  status;
   } result_type;

endpackage

// File: hdl/bpa_req_if.sv
interface bpa_req_if ();
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] free_address;

   modport source (output valid, output opcode, output free_address, input ready);
   modport sink (input valid, input opcode, input free_address, output ready);
endinterface

// File: hdl/bpa_rsp_if.sv
interface bpa_rsp_if ();
   logic        valid;
   logic        ready;
   logic [31:0] page_address;
   logic [1:0]  status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink (input valid, input page_address, input status, output ready);
endinterface

// File: hdl/bpa_ram.sv
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bpa_find.sv
// Lowest clear bit of a bitmap word.
module bpa_find (
   input  logic [bpa_pkg::WORD_BITS-1:0] word,
   output logic                          found,
   output logic [bpa_pkg::WORD_BITS-1:0] onehot,
   output logic [bpa_pkg::BIT_W-1:0]     index
);

   always_comb begin
      onehot = ~word & (word + bpa_pkg::WORD_BITS'(1));
      found  = ~&word;
      index  = '0;
      for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
         if (onehot[b]) begin
            index = index | bpa_pkg::BIT_W'(b);
         end
      end
   end

endmodule

// File: hdl/bpa_engine.sv
// Bitmap sequencer: clearing pass, first-fit scan, free read-modify-write.
module bpa_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   opcode,
   input  logic [31:0]            free_address,
   input  logic [31:0]            base_address,
   input  logic                   slot_free,
   output logic                   idle,
   output logic                   done,
   output bpa_pkg::result_type    result
);

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd3;
   localparam logic [2:0] S_FREE_WR = 3'd4;
   localparam logic [2:0] S_DONE    = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [bpa_pkg::WIDX_W-1:0]     idx_ff, idx_in;       // scan / clear address
   logic                           chk_vld_ff, chk_vld_in;
   logic [bpa_pkg::WIDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [bpa_pkg::PIDX_W-1:0]     page_ff, page_in;
   logic [1:0]                     status_ff, status_in;

   logic                           wr_en, rd_en;
   logic [bpa_pkg::WIDX_W-1:0]     wr_addr, rd_addr;
   logic [bpa_pkg::WORD_BITS-1:0]  wr_data, rd_data, masked;
   logic                           found;
   logic [bpa_pkg::WORD_BITS-1:0]  onehot;
   logic [bpa_pkg::BIT_W-1:0]      bit_idx;

   logic [31:0]                    diff, page32;
   logic [31:0]                    offset;

   bpa_ram #(
      .WIDTH (bpa_pkg::WORD_BITS),
      .DEPTH (bpa_pkg::WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign masked = rd_data | ((chk_idx_ff == bpa_pkg::LAST_WORD) ? bpa_pkg::LAST_PAD : '0);

   bpa_find u_find (
      .word   (masked),
      .found  (found),
      .onehot (onehot),
      .index  (bit_idx)
   );

   assign diff   = free_address - base_address;
   assign page32 = diff >> bpa_pkg::PAGE_SHIFT;
   assign offset = 32'(page_ff) << bpa_pkg::PAGE_SHIFT;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      page_in    = page_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = idx_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == bpa_pkg::LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + bpa_pkg::WIDX_W'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               if (opcode == bpa_pkg::OP_ALLOC) begin
                  state_in = S_SCAN;
               end else if (page32 < 32'(bpa_pkg::PAGE_COUNT)) begin
                  page_in  = page32[bpa_pkg::PIDX_W-1:0];
                  state_in = S_FREE_RD;
               end else begin
                  status_in = bpa_pkg::ST_BAD_ADDRESS;
                  state_in  = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // one word read per cycle, checked in the next cycle
            if (chk_vld_ff && found) begin
               wr_en     = 1'b1;
               wr_addr   = chk_idx_ff;
               wr_data   = rd_data | onehot;
               page_in   = {chk_idx_ff, bit_idx};
               status_in = bpa_pkg::ST_ALLOCATED;
               state_in  = S_DONE;
            end else if (chk_vld_ff && chk_idx_ff == bpa_pkg::LAST_WORD) begin
               status_in = bpa_pkg::ST_NO_MEMORY;
               state_in  = S_DONE;
            end else begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = idx_ff;
               if (idx_ff != bpa_pkg::LAST_WORD) begin
                  idx_in = idx_ff + bpa_pkg::WIDX_W'(1);
               end
            end
         end
         S_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = page_ff[bpa_pkg::PIDX_W-1:bpa_pkg::BIT_W];
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            wr_en     = 1'b1;
            wr_addr   = page_ff[bpa_pkg::PIDX_W-1:bpa_pkg::BIT_W];
            wr_data   = rd_data &
                        ~(bpa_pkg::WORD_BITS'(1) << page_ff[bpa_pkg::BIT_W-1:0]);
            status_in = bpa_pkg::ST_FREED;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         chk_vld_ff <= chk_vld_in;
      end
      chk_idx_ff <= chk_idx_in;
      page_ff    <= page_in;
      status_ff  <= status_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_DONE);

   assign result.status       = status_ff;
   assign result.page_address = (status_ff == bpa_pkg::ST_ALLOCATED) ?
                                base_address + offset : 32'd0;

endmodule

// File: hdl/bitmap_page_allocator.sv
// Channel  Dir  Word contents                      Handshake
// req      in   opcode, free_address               valid/ready
// rsp      out  page_address, status               valid/ready
// csr      in   base_address (32b)                 write enable only
//
// Allocate: a first-fit scan of the bitmap RAM, one word per cycle from
//   word 0; the lowest free page of the first word that has one is marked
//   used and returned, else the status is no memory.
// Free: RAM read, then write back; an out-of-range address gets a bad-address status.
// Reset: a clearing pass writes every bitmap word to zero, and req.ready
//   stays low until it ends.
// Stalls: one item in flight; rsp holds in an output register, so the next
//   req word is taken while a result waits.
module bitmap_page_allocator (
   input  logic        clock,
   input  logic        reset,
   bpa_req_if.sink     req_if,
   bpa_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0]         base_address_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   bpa_pkg::result_type rsp_word_ff;
   bpa_pkg::result_type result;
   logic                idle, done, slot_free, start;

   // base address register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= bpa_pkg::BASE_RESET;
      end else if (csr_write_enable) begin
         base_address_ff <= csr_write_data;
      end
   end

   assign start         = req_if.valid & idle;
   assign req_if.ready  = idle;

   // output slot is free when empty or being drained this cycle
   assign slot_free = ~rsp_valid_ff | rsp_if.ready;

   bpa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .opcode       (req_if.opcode),
      .free_address (req_if.free_address),
      .base_address (base_address_ff),
      .slot_free    (slot_free),
      .idle         (idle),
      .done         (done),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done && slot_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (done && slot_free) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.page_address = rsp_word_ff.page_address;
   assign rsp_if.status       = rsp_word_ff.status;

endmodule
